FILE: hw/rtl/lpbf_pkg.sv
// Shared types and constants for the lidar point box and validity filter.
package lpbf_pkg;

   // Fixed-point coordinate format
   localparam int FRAC_BITS = 10;
   localparam int COORD_W   = 17;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sd65535;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -17'sd65536;

   // Float single layout
   localparam int MANT_W    = 24;                  // with hidden bit
   localparam int LSHIFT_MAX = 20;                 // larger left shifts saturate
   localparam int MAG_W     = MANT_W + LSHIFT_MAX + 1;
   localparam logic [9:0] SHIFT_BIAS = 10'(150 - FRAC_BITS);

   // Bounds grown by the margin need one extra bit
   localparam int MARGIN_W = 10;
   localparam int BOUND_W  = COORD_W + 1;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd51;

   // Frame counters
   localparam int CNT_W   = 17;
   localparam int IDX_W   = 16;
   localparam logic [CNT_W-1:0] COUNT_CAP = 17'd65536;
   localparam logic [CNT_W-1:0] IDX_MAX   = 17'd65535;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MARGIN = 3'd6;

   // Per-point verdict
   typedef enum logic [1:0] {
      VERDICT_KEPT     = 2'd0,
      VERDICT_INVALID  = 2'd1,
      VERDICT_SELF_HIT = 2'd2
   } verdict_type;

endpackage

FILE: hw/rtl/lpbf_to_fixed.sv
// Float single to saturated signed fixed point converter, floor rounding.
module lpbf_to_fixed (
   input  logic [31:0]                          bits,
   output logic signed [lpbf_pkg::COORD_W-1:0]  fixed
);

   logic                          neg;
   logic [7:0]                    ex;
   logic [lpbf_pkg::MANT_W-1:0]   man;
   logic [9:0]                    e_eff;
   logic [9:0]                    shift_l;
   logic [9:0]                    shift_r;
   logic                          right;
   logic [lpbf_pkg::MAG_W-1:0]    mag;
   logic [lpbf_pkg::MAG_W-1:0]    mag_adj;
   logic                          frac;

   // Unpack and find the shift that lines the mantissa up with the fraction bits
   always_comb begin
      neg     = bits[31];
      ex      = bits[30:23];
      man     = {(ex != 8'd0), bits[22:0]};
      e_eff   = (ex == 8'd0) ? 10'd1 : {2'b00, ex};
      right   = (e_eff < lpbf_pkg::SHIFT_BIAS);
      shift_l = e_eff - lpbf_pkg::SHIFT_BIAS;
      shift_r = lpbf_pkg::SHIFT_BIAS - e_eff;
   end

   // Magnitude with sticky fraction, then floor and clamp
   always_comb begin
      mag     = '0;
      frac    = 1'b0;
      mag_adj = '0;
      fixed   = '0;
      if (man == '0) begin
         fixed = '0;
      end else if (!right && shift_l > 10'(lpbf_pkg::LSHIFT_MAX)) begin
         fixed = neg ? lpbf_pkg::COORD_MIN : lpbf_pkg::COORD_MAX;
      end else begin
         if (!right) begin
            mag = lpbf_pkg::MAG_W'(man) << shift_l[4:0];
         end else if (shift_r >= 10'(lpbf_pkg::MANT_W)) begin
            frac = 1'b1;
         end else begin
            mag  = lpbf_pkg::MAG_W'(man >> shift_r[4:0]);
            frac = |(man & ~({lpbf_pkg::MANT_W{1'b1}} << shift_r[4:0]));
         end
         if (!neg) begin
            fixed = (mag > lpbf_pkg::MAG_W'(lpbf_pkg::COORD_MAX)) ?
                    lpbf_pkg::COORD_MAX : $signed(mag[lpbf_pkg::COORD_W-1:0]);
         end else begin
            // floor of a negative value rounds the magnitude up
            mag_adj = mag + lpbf_pkg::MAG_W'(frac);
            if (mag_adj > lpbf_pkg::MAG_W'(65536)) begin
               fixed = lpbf_pkg::COORD_MIN;
            end else begin
               fixed = $signed(~mag_adj[lpbf_pkg::COORD_W-1:0] + 17'd1);
            end
         end
      end
   end

endmodule

FILE: hw/rtl/lidar_point_box_and_validity_filter.sv
// Top level: lidar point validity check, ego box crop and frame counting.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | x_bits, y_bits, z_bits, frame_end
//  rsp_    | out       | rsp_valid/rsp_stall | verdict, dest_index, frame_done, counts
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One point per cycle sustained while rsp_stall is low; a point's result is presented
// from the result register (input register, then result register after conversion
// and box test). Synchronous active-high reset clears the pipeline, counters and
// registers (box bounds 0, margin 51). The input stalls only when both pipeline
// registers are full and the result side stalls. csr_ready is always high.
module lidar_point_box_and_validity_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   // point input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [31:0]                           req_x_bits,
   input  logic [31:0]                           req_y_bits,
   input  logic [31:0]                           req_z_bits,
   input  logic                                  req_frame_end,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lpbf_pkg::verdict_type                 rsp_verdict,
   output logic [lpbf_pkg::IDX_W-1:0]            rsp_dest_index,
   output logic                                  rsp_frame_done,
   output logic [lpbf_pkg::CNT_W-1:0]            rsp_total_count,
   output logic [lpbf_pkg::CNT_W-1:0]            rsp_kept_count,
   output logic [lpbf_pkg::CNT_W-1:0]            rsp_self_hit_count,
   output logic [lpbf_pkg::CNT_W-1:0]            rsp_invalid_count,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lpbf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lpbf_pkg::COORD_W-1:0]          csr_data
);

   // configuration registers
   logic signed [lpbf_pkg::COORD_W-1:0] box_x_low_ff, box_x_high_ff;
   logic signed [lpbf_pkg::COORD_W-1:0] box_y_low_ff, box_y_high_ff;
   logic signed [lpbf_pkg::COORD_W-1:0] box_z_low_ff, box_z_high_ff;
   logic [lpbf_pkg::MARGIN_W-1:0]       box_margin_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic        s1_end_ff;

   // frame counters
   logic [lpbf_pkg::CNT_W-1:0] seen_ff, seen_in;
   logic [lpbf_pkg::CNT_W-1:0] kept_ff, kept_in;
   logic [lpbf_pkg::CNT_W-1:0] self_ff, self_in;
   logic [lpbf_pkg::CNT_W-1:0] inval_ff, inval_in;

   // result register
   logic                          s2_valid_ff, s2_valid_in;
   lpbf_pkg::verdict_type         verdict_ff, verdict_in;
   logic [lpbf_pkg::IDX_W-1:0]    dest_ff, dest_in;
   logic                          done_ff;
   logic [lpbf_pkg::CNT_W-1:0]    total_ff, total_in;
   logic [lpbf_pkg::CNT_W-1:0]    kept_out_ff, kept_out_in;
   logic [lpbf_pkg::CNT_W-1:0]    self_out_ff, self_out_in;
   logic [lpbf_pkg::CNT_W-1:0]    inval_out_ff, inval_out_in;

   logic adv2;
   logic adv1;
   logic take;

   logic signed [lpbf_pkg::COORD_W-1:0] px, py, pz;
   logic signed [lpbf_pkg::BOUND_W-1:0] margin_s;
   logic signed [lpbf_pkg::BOUND_W-1:0] gx_lo, gx_hi, gy_lo, gy_hi, gz_lo, gz_hi;
   logic signed [lpbf_pkg::BOUND_W-1:0] ex_x, ex_y, ex_z;
   logic finite;
   logic in_box;
   logic [lpbf_pkg::CNT_W-1:0] seen_inc, kept_inc, self_inc, inval_inc;

   // pipeline flow control
   assign adv2      = !s2_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign take      = s1_valid_ff && adv2;
   assign csr_ready = 1'b1;

   // configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_low_ff  <= '0;
         box_x_high_ff <= '0;
         box_y_low_ff  <= '0;
         box_y_high_ff <= '0;
         box_z_low_ff  <= '0;
         box_z_high_ff <= '0;
         box_margin_ff <= lpbf_pkg::MARGIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lpbf_pkg::CSR_BOX_X_LOW:  box_x_low_ff  <= $signed(csr_data);
            lpbf_pkg::CSR_BOX_X_HIGH: box_x_high_ff <= $signed(csr_data);
            lpbf_pkg::CSR_BOX_Y_LOW:  box_y_low_ff  <= $signed(csr_data);
            lpbf_pkg::CSR_BOX_Y_HIGH: box_y_high_ff <= $signed(csr_data);
            lpbf_pkg::CSR_BOX_Z_LOW:  box_z_low_ff  <= $signed(csr_data);
            lpbf_pkg::CSR_BOX_Z_HIGH: box_z_high_ff <= $signed(csr_data);
            lpbf_pkg::CSR_BOX_MARGIN: box_margin_ff <= csr_data[lpbf_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_x_ff   <= req_x_bits;
         s1_y_ff   <= req_y_bits;
         s1_z_ff   <= req_z_bits;
         s1_end_ff <= req_frame_end;
      end
   end

   // coordinate conversion
   lpbf_to_fixed u_fix_x (.bits(s1_x_ff), .fixed(px));
   lpbf_to_fixed u_fix_y (.bits(s1_y_ff), .fixed(py));
   lpbf_to_fixed u_fix_z (.bits(s1_z_ff), .fixed(pz));

   // box grown by the margin, and the box test
   always_comb begin
      margin_s = $signed({{(lpbf_pkg::BOUND_W-lpbf_pkg::MARGIN_W){1'b0}}, box_margin_ff});
      gx_lo    = lpbf_pkg::BOUND_W'(box_x_low_ff)  - margin_s;
      gx_hi    = lpbf_pkg::BOUND_W'(box_x_high_ff) + margin_s;
      gy_lo    = lpbf_pkg::BOUND_W'(box_y_low_ff)  - margin_s;
      gy_hi    = lpbf_pkg::BOUND_W'(box_y_high_ff) + margin_s;
      gz_lo    = lpbf_pkg::BOUND_W'(box_z_low_ff)  - margin_s;
      gz_hi    = lpbf_pkg::BOUND_W'(box_z_high_ff) + margin_s;
      ex_x     = lpbf_pkg::BOUND_W'(px);
      ex_y     = lpbf_pkg::BOUND_W'(py);
      ex_z     = lpbf_pkg::BOUND_W'(pz);
      finite   = (s1_x_ff[30:23] != 8'hFF) && (s1_y_ff[30:23] != 8'hFF) &&
                 (s1_z_ff[30:23] != 8'hFF);
      in_box   = (gx_hi > gx_lo) &&
                 (ex_x >= gx_lo) && (ex_x <= gx_hi) &&
                 (ex_y >= gy_lo) && (ex_y <= gy_hi) &&
                 (ex_z >= gz_lo) && (ex_z <= gz_hi);
   end

   // saturating counter increments
   assign seen_inc  = (seen_ff  < lpbf_pkg::COUNT_CAP) ? seen_ff  + 17'd1 : seen_ff;
   assign kept_inc  = (kept_ff  < lpbf_pkg::COUNT_CAP) ? kept_ff  + 17'd1 : kept_ff;
   assign self_inc  = (self_ff  < lpbf_pkg::COUNT_CAP) ? self_ff  + 17'd1 : self_ff;
   assign inval_inc = (inval_ff < lpbf_pkg::COUNT_CAP) ? inval_ff + 17'd1 : inval_ff;

   // verdict, index and frame totals
   always_comb begin
      seen_in      = seen_inc;
      kept_in      = kept_ff;
      self_in      = self_ff;
      inval_in     = inval_ff;
      dest_in      = '0;
      if (!finite) begin
         verdict_in = lpbf_pkg::VERDICT_INVALID;
         inval_in   = inval_inc;
      end else if (in_box) begin
         verdict_in = lpbf_pkg::VERDICT_SELF_HIT;
         self_in    = self_inc;
      end else begin
         verdict_in = lpbf_pkg::VERDICT_KEPT;
         dest_in    = (kept_ff < lpbf_pkg::IDX_MAX) ? kept_ff[lpbf_pkg::IDX_W-1:0]
                                                    : lpbf_pkg::IDX_MAX[lpbf_pkg::IDX_W-1:0];
         kept_in    = kept_inc;
      end
      total_in     = s1_end_ff ? seen_in  : '0;
      kept_out_in  = s1_end_ff ? kept_in  : '0;
      self_out_in  = s1_end_ff ? self_in  : '0;
      inval_out_in = s1_end_ff ? inval_in : '0;
   end

   // counters advance once per transferred point, clearing after the frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         kept_ff  <= '0;
         self_ff  <= '0;
         inval_ff <= '0;
      end else if (take) begin
         seen_ff  <= s1_end_ff ? '0 : seen_in;
         kept_ff  <= s1_end_ff ? '0 : kept_in;
         self_ff  <= s1_end_ff ? '0 : self_in;
         inval_ff <= s1_end_ff ? '0 : inval_in;
      end
   end

   // result register
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         verdict_ff   <= verdict_in;
         dest_ff      <= dest_in;
         done_ff      <= s1_end_ff;
         total_ff     <= total_in;
         kept_out_ff  <= kept_out_in;
         self_out_ff  <= self_out_in;
         inval_out_ff <= inval_out_in;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_dest_index     = dest_ff;
   assign rsp_frame_done     = done_ff;
   assign rsp_total_count    = total_ff;
   assign rsp_kept_count     = kept_out_ff;
   assign rsp_self_hit_count = self_out_ff;
   assign rsp_invalid_count  = inval_out_ff;

endmodule

FILE: bench/lpbf_checker.sv
// Result checker for the lidar point filter: predicts each point's verdict and frame counts.
`timescale 1ns / 1ps
module lpbf_checker
   import lpbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [31:0]           req_x_bits,
   input  logic [31:0]           req_y_bits,
   input  logic [31:0]           req_z_bits,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  verdict_type           rsp_verdict,
   input  logic [IDX_W-1:0]      rsp_dest_index,
   input  logic                  rsp_frame_done,
   input  logic [CNT_W-1:0]      rsp_total_count,
   input  logic [CNT_W-1:0]      rsp_kept_count,
   input  logic [CNT_W-1:0]      rsp_self_hit_count,
   input  logic [CNT_W-1:0]      rsp_invalid_count,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_data,
   output int                    fail_count,
   output int                    results_due
);

   localparam int COUNT_LIMIT = int'(COUNT_CAP);
   localparam int IDX_LIMIT   = int'(IDX_MAX);

   typedef struct packed {
      verdict_type         verdict;
      logic [IDX_W-1:0]    dest_index;
      logic                frame_done;
      logic [CNT_W-1:0]    total_count;
      logic [CNT_W-1:0]    kept_count;
      logic [CNT_W-1:0]    self_hit_count;
      logic [CNT_W-1:0]    invalid_count;
   } point_result_t;

   point_result_t pending_results[$];

   // Shadow of the box registers and the frame counters
   int box_bound[6];
   int grow_margin;
   int frame_seen, frame_kept, frame_hit, frame_bad;

   initial fail_count = 0;

   // Floor of the float times 2^FRAC_BITS, clamped to the 17-bit signed range
   function automatic int fixed_floor(logic [31:0] bits);
      int exponent, shift;
      longint unsigned mant, mag;
      logic frac;
      exponent = bits[30:23];
      mant = bits[22:0];
      frac = 1'b0;
      if (exponent == 0) begin
         exponent = 1;
      end else begin
         mant = mant | 64'h80_0000;
      end
      if (mant == 0) return 0;
      shift = exponent - 150 + FRAC_BITS;
      if (shift >= 0) begin
         if (shift > LSHIFT_MAX) return bits[31] ? int'(COORD_MIN) : int'(COORD_MAX);
         mag = mant << shift;
      end else if (-shift >= 40) begin
         mag = 0;
         frac = 1'b1;
      end else begin
         mag = mant >> (-shift);
         frac = (mant & ((64'd1 << (-shift)) - 64'd1)) != 0;
      end
      if (!bits[31]) return (mag > 65535) ? int'(COORD_MAX) : int'(mag);
      if (frac) mag = mag + 1;
      if (mag > 65536) return int'(COORD_MIN);
      return -int'(mag);
   endfunction

   function automatic int sat_inc(int count);
      return (count < COUNT_LIMIT) ? count + 1 : count;
   endfunction

   task automatic clear_frame();
      frame_seen = 0;
      frame_kept = 0;
      frame_hit  = 0;
      frame_bad  = 0;
   endtask

   // Expected result of the point in the current req_ transfer
   task automatic classify_point();
      point_result_t r;
      logic [31:0] coord_bits[3];
      int pos;
      logic in_box;
      coord_bits[0] = req_x_bits;
      coord_bits[1] = req_y_bits;
      coord_bits[2] = req_z_bits;
      r = '0;
      r.verdict = VERDICT_KEPT;
      frame_seen = sat_inc(frame_seen);
      if (&coord_bits[0][30:23] || &coord_bits[1][30:23] || &coord_bits[2][30:23]) begin
         // non-finite wins over the box test
         r.verdict = VERDICT_INVALID;
         frame_bad = sat_inc(frame_bad);
      end else begin
         in_box = (box_bound[1] + grow_margin) > (box_bound[0] - grow_margin);
         for (int axis = 0; axis < 3; axis++) begin
            pos = fixed_floor(coord_bits[axis]);
            if (pos < box_bound[2*axis] - grow_margin ||
                pos > box_bound[2*axis+1] + grow_margin) in_box = 1'b0;
         end
         if (in_box) begin
            r.verdict = VERDICT_SELF_HIT;
            frame_hit = sat_inc(frame_hit);
         end else begin
            r.dest_index = IDX_W'((frame_kept < IDX_LIMIT) ? frame_kept : IDX_LIMIT);
            frame_kept = sat_inc(frame_kept);
         end
      end
      // frame totals ride on the last point, then start over
      if (req_frame_end) begin
         r.frame_done     = 1'b1;
         r.total_count    = CNT_W'(frame_seen);
         r.kept_count     = CNT_W'(frame_kept);
         r.self_hit_count = CNT_W'(frame_hit);
         r.invalid_count  = CNT_W'(frame_bad);
         clear_frame();
      end
      pending_results.push_back(r);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      point_result_t want;
      if (pending_results.size() == 0) begin
         $error("result transfer with no point outstanding");
         fail_count++;
      end else begin
         want = pending_results.pop_front();
         compare_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
         compare_field("dest_index", 32'(want.dest_index), 32'(rsp_dest_index));
         compare_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
         compare_field("total_count", 32'(want.total_count), 32'(rsp_total_count));
         compare_field("kept_count", 32'(want.kept_count), 32'(rsp_kept_count));
         compare_field("self_hit_count", 32'(want.self_hit_count), 32'(rsp_self_hit_count));
         compare_field("invalid_count", 32'(want.invalid_count), 32'(rsp_invalid_count));
      end
   endtask

   // Watch all three channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         pending_results.delete();
         for (int k = 0; k < 6; k++) box_bound[k] = 0;
         grow_margin = int'(MARGIN_RESET);
         clear_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index <= CSR_BOX_Z_HIGH)
               box_bound[csr_index] = int'($signed(csr_data));
            else if (csr_index == CSR_BOX_MARGIN)
               grow_margin = int'(csr_data[MARGIN_W-1:0]);
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) classify_point();
      end
      results_due = pending_results.size();
   end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the lidar point filter: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps
module tb_top;
   import lpbf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;   // no register behind it
   localparam int STALL_PCT         = 6;
   localparam int HOLD_CYCLES       = 60;
   localparam int WATCHDOG_LIMIT    = 1000;
   localparam int PHASES            = 6;
   localparam int PHASE_POINTS      = 230;
   localparam int LONG_FRAME_POINTS = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [31:0]           req_x_bits = '0;
   logic [31:0]           req_y_bits = '0;
   logic [31:0]           req_z_bits = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   verdict_type           rsp_verdict;
   logic [IDX_W-1:0]      rsp_dest_index;
   logic                  rsp_frame_done;
   logic [CNT_W-1:0]      rsp_total_count;
   logic [CNT_W-1:0]      rsp_kept_count;
   logic [CNT_W-1:0]      rsp_self_hit_count;
   logic [CNT_W-1:0]      rsp_invalid_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [COORD_W-1:0]    csr_data = '0;
   int                    fail_count;
   int                    results_due;

   bit no_gaps = 1'b0;        // both sides run without idling
   bit hold_request = 1'b0;   // asks the result side for one long hold-off
   int cur_box[6];
   int cur_margin;

   always #1 clock = ~clock;

   lidar_point_box_and_validity_filter DUT (.*);
   lpbf_checker point_checker (.*);

   function automatic int clamp_coord(int v);
      if (v < int'(COORD_MIN)) return int'(COORD_MIN);
      if (v > int'(COORD_MAX)) return int'(COORD_MAX);
      return v;
   endfunction

   // Float bits for v / 2^FRAC_BITS, optionally with random bits below the LSB
   function automatic logic [31:0] fixed_to_float(int v, bit fuzz);
      int mag, msb;
      logic [22:0] mant;
      if (v == 0) return 32'h0;
      mag = (v < 0) ? -v : v;
      msb = 0;
      for (int b = 0; b < 18; b++) if (mag[b]) msb = b;
      mant = 23'(mag << (23 - msb));
      if (fuzz) mant = mant | (23'($urandom) & ((23'd1 << (23 - msb)) - 23'd1));
      return {v < 0, 8'(msb - FRAC_BITS + 127), mant};
   endfunction

   // One coordinate: mostly near the current box, some raw bits, odd patterns and full-range values
   function automatic logic [31:0] pick_coord(int axis);
      int lo, hi, roll;
      lo = cur_box[2*axis];
      hi = cur_box[2*axis+1];
      if (lo > hi) begin
         roll = lo;
         lo = hi;
         hi = roll;
      end
      lo = lo - cur_margin - 4;
      hi = hi + cur_margin + 4;
      roll = $urandom_range(99);
      if (roll < 60)
         return fixed_to_float(clamp_coord(lo + int'($urandom_range(hi - lo))),
                               $urandom_range(1));
      if (roll < 78) return $urandom;
      if (roll < 90) begin
         case ($urandom_range(14))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0001;
            4:       return 32'h807F_FFFF;
            5:       return 32'h7F80_0000;
            6:       return 32'hFF80_0000;
            7:       return 32'h7FC0_0000;
            8:       return 32'hFFFF_FFFF;
            9:       return 32'h7F7F_FFFF;
            10:      return 32'hFF7F_FFFF;
            11:      return 32'h4280_0000;
            12:      return 32'hC280_0000;
            13:      return 32'h427F_FFFF;
            default: return 32'hC280_0001;
         endcase
      end
      return fixed_to_float(int'(COORD_MIN) + int'($urandom_range(131071)), 1'b1);
   endfunction

   task automatic pick_axis(output int lo, output int hi);
      int centre, half;
      centre = -8192 + int'($urandom_range(16384));
      half = $urandom_range(4096);
      case ($urandom_range(5))
         0, 1, 2: begin
            lo = clamp_coord(centre - half);
            hi = clamp_coord(centre + half);
         end
         3: begin
            lo = int'(COORD_MIN);
            hi = int'(COORD_MAX);
         end
         4: begin
            // inverted range
            lo = clamp_coord(centre + half + 1);
            hi = clamp_coord(centre - half);
         end
         default: begin
            lo = int'(COORD_MIN) + int'($urandom_range(131071));
            hi = int'(COORD_MIN) + int'($urandom_range(131071));
         end
      endcase
   endtask

   // Offer one point and hold it until the transfer
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      if (!no_gaps && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_x_bits    <= x;
      req_y_bits    <= y;
      req_z_bits    <= z;
      req_frame_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Load cur_box and cur_margin into the block while it is idle
   task automatic apply_config();
      settle();
      write_reg(CSR_SPARE, COORD_W'($urandom));
      write_reg(CSR_BOX_X_LOW, COORD_W'(cur_box[0]));
      write_reg(CSR_BOX_X_HIGH, COORD_W'(cur_box[1]));
      write_reg(CSR_BOX_Y_LOW, COORD_W'(cur_box[2]));
      write_reg(CSR_BOX_Y_HIGH, COORD_W'(cur_box[3]));
      write_reg(CSR_BOX_Z_LOW, COORD_W'(cur_box[4]));
      write_reg(CSR_BOX_Z_HIGH, COORD_W'(cur_box[5]));
      write_reg(CSR_BOX_MARGIN, {7'($urandom), MARGIN_W'(cur_margin)});
      csr_valid <= 1'b0;
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_gaps && ($urandom_range(99) < STALL_PCT);
         end
      end
   end

   // Watchdog: too long without any transfer
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Stimulus
   initial begin
      int lo, hi;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config: box at the origin grown by 51
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h8000_0001, 32'h0000_0001, 32'h807F_FFFF, 1'b0);   // tiny negatives
      send_point(32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);   // NaN inside box
      send_point(32'h0000_0000, 32'h7F80_0000, 32'h0000_0000, 1'b0);
      send_point(32'h0000_0000, 32'h0000_0000, 32'hFF80_0000, 1'b0);
      send_point(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4974_2400, 1'b0);   // saturating
      send_point(32'h4280_0000, 32'hC280_0000, 32'h427F_FFFF, 1'b0);
      send_point(32'hBF00_0000, 32'h3D4C_CCCD, 32'h0000_0000, 1'b0);
      send_point(32'h3D4C_CCCD, 32'hBD4C_CCCD, 32'h0000_0000, 1'b0);
      send_point(32'h3D4C_CCCD, 32'h3D4C_CCCD, 32'h3D4C_CCCD, 1'b0);   // on the grown face
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_point(32'h0080_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);   // one-point frame

      // box covering the whole range, widest margin
      cur_box = '{-65536, 65535, -65536, 65535, -65536, 65535};
      cur_margin = 1023;
      apply_config();
      send_point(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4974_2400, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);

      // inverted x: box test off
      cur_box = '{100, -1000, -65536, 65535, -65536, 65535};
      cur_margin = 0;
      apply_config();
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);

      // empty x: grown high equals grown low
      cur_box = '{500, 500, -65536, 65535, -65536, 65535};
      apply_config();
      send_point(fixed_to_float(500, 1'b0), 32'h0000_0000, 32'h0000_0000, 1'b0);

      // x fine, y inverted: nothing inside
      cur_box = '{-1000, 1000, 10, -10, -65536, 65535};
      apply_config();
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);

      // longer frame with one invalid and one self-hit point
      cur_box = '{-1024, 1024, -1024, 1024, -1024, 1024};
      cur_margin = 51;
      apply_config();
      for (int i = 0; i < LONG_FRAME_POINTS; i++) begin
         if (i % 9973 == 5)
            send_point(32'h7FC0_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
         else if (i % 7919 == 3)
            send_point(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
         else
            send_point(fixed_to_float(2000 + i % 30000, 1'b1),
                       fixed_to_float(-(i % 5000), 1'b1),
                       fixed_to_float(i % 65535 - 32768, 1'b0),
                       i == LONG_FRAME_POINTS - 1);
      end

      // random phases, each with its own box
      for (int p = 0; p < PHASES; p++) begin
         for (int axis = 0; axis < 3; axis++) begin
            pick_axis(lo, hi);
            cur_box[2*axis]   = lo;
            cur_box[2*axis+1] = hi;
         end
         case ($urandom_range(3))
            0:       cur_margin = 0;
            1:       cur_margin = 1023;
            default: cur_margin = $urandom_range(1023);
         endcase
         apply_config();
         no_gaps = (p == 2);
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (p == 3 && n == 40) hold_request = 1'b1;
            send_point(pick_coord(0), pick_coord(1), pick_coord(2), $urandom_range(31) == 0);
         end
      end
      no_gaps = 1'b0;

      settle();
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lpbf_pkg.sv
hw/rtl/lpbf_to_fixed.sv
hw/rtl/lidar_point_box_and_validity_filter.sv
bench/lpbf_checker.sv
bench/tb_top.sv
